// ----- hw/rtl/dual_encoder_speed_filter_assert.svh -----
// Assertion macros for the encoder speed filter; expect clk and rst_n in scope.
`ifndef DUAL_ENCODER_SPEED_FILTER_ASSERT_SVH
`define DUAL_ENCODER_SPEED_FILTER_ASSERT_SVH

// Consequent checked in the same cycle.
`define DESF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the next cycle.
`define DESF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/desf_pkg.sv -----
`default_nettype none

package desf_pkg;

    localparam int CNT_W   = 16;
    localparam int POS_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_A    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_B    = 2'd3;

    // register reset values
    localparam logic [7:0] SPEED_SCALE_RST = 8'd15;
    localparam logic [7:0] FILTER_GAIN_RST = 8'd13;
    localparam logic       INVERT_A_RST    = 1'b0;
    localparam logic       INVERT_B_RST    = 1'b1;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic signed [CNT_W-1:0] spd_t;
    typedef logic signed [POS_W-1:0] pos_t;

endpackage

`default_nettype wire

// ----- hw/rtl/desf_if.sv -----
`default_nettype none

interface desf_in_if;
    logic             valid;
    logic             ready;
    desf_pkg::cnt_t   count_a;
    desf_pkg::cnt_t   count_b;

    modport source (output valid, output count_a, output count_b, input ready);
    modport sink   (input valid, input count_a, input count_b, output ready);
endinterface

interface desf_out_if;
    logic             valid;
    logic             ready;
    desf_pkg::spd_t   speed_a;
    desf_pkg::spd_t   speed_b;
    desf_pkg::spd_t   smooth_a;
    desf_pkg::spd_t   smooth_b;
    desf_pkg::pos_t   position_a;
    desf_pkg::pos_t   position_b;

    modport source (output valid, output speed_a, output speed_b, output smooth_a,
                    output smooth_b, output position_a, output position_b,
                    input ready);
    modport sink   (input valid, input speed_a, input speed_b, input smooth_a,
                    input smooth_b, input position_a, input position_b,
                    output ready);
endinterface

interface desf_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [desf_pkg::CFG_IDX_W-1:0]       index;
    logic [desf_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dual_encoder_speed_filter.sv -----
`default_nettype none
`include "dual_encoder_speed_filter_assert.svh"

// Dual encoder speed filter. Each tick item carries two 16-bit counter values;
// every second tick is a sample tick that produces one result item with the
// unfiltered speed, the EMA-smoothed speed and the 32-bit position of both
// channels. A sample tick is processed from acceptance to the result register
// with one 17x9 multiplier, shared by both channels and both multiplications
// (delta*scale, diff*gain), sequenced as five steps per channel plus load.
// Ticks are taken while a finished result waits at the output; a following
// sample tick waits only if that result is still untaken when its own is
// ready. Configuration writes are taken in any cycle and must be issued
// while the block is idle.
module dual_encoder_speed_filter (
    input  wire             clk,
    input  wire             rst_n,
    desf_in_if.sink         tick,
    desf_out_if.source      result,
    desf_cfg_if.sink        cfg
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DELTA = 3'd1;
    localparam logic [2:0] S_POS   = 3'd2;
    localparam logic [2:0] S_SPEED = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_EMA   = 3'd5;
    localparam logic [2:0] S_LOAD  = 3'd6;

    localparam int PROD_W = 26;

    logic [2:0]           state_reg, state_next;
    logic                 ch_reg;
    logic                 phase_reg;

    logic [7:0]           speed_scale_reg;
    logic [7:0]           filter_gain_reg;
    logic                 invert_a_reg;
    logic                 invert_b_reg;

    desf_pkg::cnt_t       cnt_reg   [2];
    desf_pkg::cnt_t       prev_reg  [2];
    desf_pkg::pos_t       pos_reg   [2];
    desf_pkg::spd_t       ema_reg   [2];
    desf_pkg::spd_t       speed_reg [2];
    desf_pkg::cnt_t       delta_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                 out_valid_reg;
    desf_pkg::spd_t       out_speed_reg  [2];
    desf_pkg::spd_t       out_smooth_reg [2];
    desf_pkg::pos_t       out_pos_reg    [2];

    logic                 tick_acc;
    logic                 out_free;
    logic signed [16:0]   op_a;
    logic signed [8:0]    op_b;
    logic signed [PROD_W-1:0] prod;
    desf_pkg::spd_t       diff;
    desf_pkg::spd_t       raw_speed;
    desf_pkg::spd_t       speed_val;
    logic                 inv_sel;
    logic signed [PROD_W-1:0] prod_shr;
    logic                 round_up;
    desf_pkg::spd_t       step;

    assign tick.ready = (state_reg == S_IDLE);
    assign tick_acc   = tick.valid && tick.ready;
    assign cfg.ready  = 1'b1;
    assign out_free   = !out_valid_reg || result.ready;

    // shared multiplier: delta*scale in S_POS, diff*gain in S_MUL2
    assign diff = speed_reg[ch_reg] - ema_reg[ch_reg];
    always_comb
    begin
        if (state_reg == S_POS)
        begin
            op_a = $signed({1'b0, delta_reg});
            op_b = $signed({1'b0, speed_scale_reg});
        end
        else
        begin
            op_a = $signed({diff[15], diff});
            op_b = $signed({1'b0, filter_gain_reg});
        end
    end
    assign prod = op_a * op_b;

    assign inv_sel   = ch_reg ? invert_b_reg : invert_a_reg;
    assign raw_speed = prod_reg[15:0];
    assign speed_val = inv_sel ? -raw_speed : raw_speed;

    // divide by 128 truncating toward zero
    assign prod_shr = prod_reg >>> 7;
    assign round_up = prod_reg[PROD_W-1] && (prod_reg[6:0] != 7'd0);
    assign step     = prod_shr[15:0] + {15'd0, round_up};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (tick_acc && phase_reg) state_next = S_DELTA;
            S_DELTA: state_next = S_POS;
            S_POS:   state_next = S_SPEED;
            S_SPEED: state_next = S_MUL2;
            S_MUL2:  state_next = S_EMA;
            S_EMA:   state_next = ch_reg ? S_LOAD : S_DELTA;
            S_LOAD:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ch_reg          <= 1'b0;
            phase_reg       <= 1'b0;
            speed_scale_reg <= desf_pkg::SPEED_SCALE_RST;
            filter_gain_reg <= desf_pkg::FILTER_GAIN_RST;
            invert_a_reg    <= desf_pkg::INVERT_A_RST;
            invert_b_reg    <= desf_pkg::INVERT_B_RST;
            prev_reg[0]     <= '0;
            prev_reg[1]     <= '0;
            pos_reg[0]      <= '0;
            pos_reg[1]      <= '0;
            ema_reg[0]      <= '0;
            ema_reg[1]      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    desf_pkg::CFG_SPEED_SCALE: speed_scale_reg <= cfg.data;
                    desf_pkg::CFG_FILTER_GAIN: filter_gain_reg <= cfg.data;
                    desf_pkg::CFG_INVERT_A:    invert_a_reg    <= cfg.data[0];
                    desf_pkg::CFG_INVERT_B:    invert_b_reg    <= cfg.data[0];
                    default: ;
                endcase
            end

            if (tick_acc)
            begin
                phase_reg <= !phase_reg;
                ch_reg    <= 1'b0;
            end

            if (state_reg == S_DELTA)
                prev_reg[ch_reg] <= cnt_reg[ch_reg];
            if (state_reg == S_POS)
                pos_reg[ch_reg] <= pos_reg[ch_reg]
                                   + {{(desf_pkg::POS_W-16){delta_reg[15]}}, delta_reg};
            if (state_reg == S_EMA)
            begin
                ema_reg[ch_reg] <= ema_reg[ch_reg] + step;
                ch_reg          <= 1'b1;
            end

            if (state_reg == S_LOAD && out_free)
                out_valid_reg <= 1'b1;
            else if (result.valid && result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            cnt_reg[0] <= tick.count_a;
            cnt_reg[1] <= tick.count_b;
        end
        if (state_reg == S_DELTA)
            delta_reg <= cnt_reg[ch_reg] - prev_reg[ch_reg];
        if (state_reg == S_POS || state_reg == S_MUL2)
            prod_reg <= prod;
        if (state_reg == S_SPEED)
            speed_reg[ch_reg] <= speed_val;
        if (state_reg == S_LOAD && out_free)
        begin
            out_speed_reg[0]  <= speed_reg[0];
            out_speed_reg[1]  <= speed_reg[1];
            out_smooth_reg[0] <= ema_reg[0];
            out_smooth_reg[1] <= ema_reg[1];
            out_pos_reg[0]    <= pos_reg[0];
            out_pos_reg[1]    <= pos_reg[1];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.speed_a    = out_speed_reg[0];
    assign result.speed_b    = out_speed_reg[1];
    assign result.smooth_a   = out_smooth_reg[0];
    assign result.smooth_b   = out_smooth_reg[1];
    assign result.position_a = out_pos_reg[0];
    assign result.position_b = out_pos_reg[1];

    `DESF_ASSERT_NEXT(a_skip_tick_idle, tick_acc && !phase_reg, state_reg == S_IDLE,
        "skipped tick started the sequencer")
    `DESF_ASSERT_NEXT(a_sample_starts_a, tick_acc && phase_reg,
        state_reg == S_DELTA && !ch_reg, "sample tick did not start on channel A")
    `DESF_ASSERT_NEXT(a_load_shows_result, state_reg == S_LOAD && out_free,
        out_valid_reg && state_reg == S_IDLE, "finished item not presented")
    `DESF_ASSERT_SAME(a_no_overwrite, state_reg == S_LOAD && out_valid_reg && !result.ready,
        state_next == S_LOAD, "pending result would be overwritten")

endmodule

`default_nettype wire
